FILE: sv/lsp_pkg.sv
// Package for the LDPC segmentation parameter block: item types, constants
// and the lifting size table. No dependencies.
package lsp_pkg;

  typedef struct packed {
    logic [20:0] tb_size;
    logic [10:0] code_rate;
  } lsp_in_t;

  typedef struct packed {
    logic        base_graph;
    logic [4:0]  tb_crc_len;
    logic [20:0] tb_bits_crc;
    logic [9:0]  num_blocks;
    logic [4:0]  block_crc_len;
    logic [13:0] bits_per_block;
    logic [8:0]  lifting_size;
    logic [13:0] info_bits;
    logic [13:0] filler_bits;
    logic [14:0] coded_bits;
  } lsp_out_t;

  localparam int NumLifts = 51;
  localparam logic [21:0] KcbBg1 = 22'd8448;
  localparam logic [21:0] KcbBg2 = 22'd3840;

  // Reciprocals ceil(2^36 / (Kcb - 24)); the product shifted down by 36 is the
  // exact quotient for every numerator below 2^22.
  localparam int RecipShift = 36;
  localparam logic [24:0] RecipBg1 = 25'((64'd1 << 36) / 64'd8424 + 64'd1);
  localparam logic [24:0] RecipBg2 = 25'((64'd1 << 36) / 64'd3816 + 64'd1);

  function automatic logic [8:0] lift_val(input logic [5:0] idx);
    logic [8:0] v;
    case (idx)
      6'd0: v = 9'd2;     6'd1: v = 9'd3;     6'd2: v = 9'd4;
      6'd3: v = 9'd5;     6'd4: v = 9'd6;     6'd5: v = 9'd7;
      6'd6: v = 9'd8;     6'd7: v = 9'd9;     6'd8: v = 9'd10;
      6'd9: v = 9'd11;    6'd10: v = 9'd12;   6'd11: v = 9'd13;
      6'd12: v = 9'd14;   6'd13: v = 9'd15;   6'd14: v = 9'd16;
      6'd15: v = 9'd18;   6'd16: v = 9'd20;   6'd17: v = 9'd22;
      6'd18: v = 9'd24;   6'd19: v = 9'd26;   6'd20: v = 9'd28;
      6'd21: v = 9'd30;   6'd22: v = 9'd32;   6'd23: v = 9'd36;
      6'd24: v = 9'd40;   6'd25: v = 9'd44;   6'd26: v = 9'd48;
      6'd27: v = 9'd52;   6'd28: v = 9'd56;   6'd29: v = 9'd60;
      6'd30: v = 9'd64;   6'd31: v = 9'd72;   6'd32: v = 9'd80;
      6'd33: v = 9'd88;   6'd34: v = 9'd96;   6'd35: v = 9'd104;
      6'd36: v = 9'd112;  6'd37: v = 9'd120;  6'd38: v = 9'd128;
      6'd39: v = 9'd144;  6'd40: v = 9'd160;  6'd41: v = 9'd176;
      6'd42: v = 9'd192;  6'd43: v = 9'd208;  6'd44: v = 9'd224;
      6'd45: v = 9'd240;  6'd46: v = 9'd256;  6'd47: v = 9'd288;
      6'd48: v = 9'd320;  6'd49: v = 9'd352;  6'd50: v = 9'd384;
      default: v = 9'd384;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/lsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
// No dependencies; no package import needed.
module lsp_div #(
  parameter int NumW  = 22,
  parameter int DenW  = 14,
  parameter int SideW = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [NumW-1:0]  num,
  input  logic [DenW-1:0]  den,
  input  logic [SideW-1:0] side_in,
  output logic             out_vld,
  output logic [NumW-1:0]  quot,
  output logic [DenW-1:0]  rem,
  output logic [SideW-1:0] side_out
);

  logic             vld  [NumW+1];
  logic [NumW-1:0]  q    [NumW+1];
  logic [DenW:0]    r    [NumW+1];
  logic [DenW-1:0]  d    [NumW+1];
  logic [SideW-1:0] sd   [NumW+1];

  always_comb begin
    vld[0] = in_vld;
    q[0]   = num;
    r[0]   = '0;
    d[0]   = den;
    sd[0]  = side_in;
  end

  // One shift and subtract step per register stage.
  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] trial;
    logic [DenW+1:0] shifted;
    always_comb begin
      shifted = {r[s], q[s][NumW-1]};
      trial   = shifted - {2'b00, d[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
      if (!trial[DenW+1]) begin
        r[s+1] <= trial[DenW:0];
      end else begin
        r[s+1] <= shifted[DenW:0];
      end
      q[s+1]  <= {q[s][NumW-2:0], ~trial[DenW+1]};
      d[s+1]  <= d[s];
      sd[s+1] <= sd[s];
    end
  end

  assign out_vld  = vld[NumW];
  assign quot     = q[NumW];
  assign rem      = r[NumW][DenW-1:0];
  assign side_out = sd[NumW];

endmodule

FILE: sv/lsp_lift.sv
// Lifting size selection: a registered compare of Kb*Z against K' over the
// table, then a priority pick. Depends on lsp_pkg.
module lsp_lift
  import lsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic [4:0]  kb,
  input  logic [21:0] kd,
  input  lsp_out_t    part_in,
  output logic        out_vld,
  output lsp_out_t    res
);

  logic [NumLifts-1:0] fit;
  logic                vld1;
  lsp_out_t            part1;
  logic [21:0]         kd1;

  // Stage one: compare every table entry in parallel.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    for (int i = 0; i < NumLifts; i++) begin
      fit[i] <= ({8'd0, {9'd0, kb} * {5'd0, lift_val(6'(i))}} >= kd);
    end
    part1 <= part_in;
    kd1   <= kd;
  end

  logic [8:0]  zc;
  logic [14:0] k;
  logic [15:0] n;
  lsp_out_t    res_next;

  // Stage two: first fitting entry, then K, filler and N.
  always_comb begin
    zc = 9'd384;
    for (int i = NumLifts - 1; i >= 0; i--) begin
      if (fit[i]) begin
        zc = lift_val(6'(i));
      end
    end
    if (part1.base_graph) begin
      k = 15'(zc * 10);
      n = 16'(zc * 50);
    end else begin
      k = 15'(zc * 22);
      n = 16'(zc * 66);
    end
    res_next              = part1;
    res_next.lifting_size = zc;
    res_next.info_bits    = k[13:0];
    if ({7'd0, k} >= kd1) begin
      res_next.filler_bits = 14'({7'd0, k} - kd1);
    end else begin
      res_next.filler_bits = '0;
    end
    res_next.coded_bits = n[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld1;
    end
    res <= res_next;
  end

endmodule

FILE: sv/ldpc_segmentation_params.sv
// LDPC code block segmentation parameters, top level.
// Depends on lsp_pkg, lsp_div and lsp_lift.
//
// Usage: drive din and raise start; an item is taken at each rising edge
// with start high and busy low. busy is held low, so an item may enter
// every cycle. Each result appears on dout for one cycle with done high.
// The receiver cannot stall; results leave in order.
// Pipeline, from the accepting edge to the edge that takes the result: the
// graph stage, a registered reciprocal multiply for C = ceil(B/(Kcb-24)),
// the numerator stage, two 22-stage pipelined dividers in parallel (B/C
// and B'/C) and the two-stage lifting compare. Throughput is one item per
// cycle.
// Reset clears all valid bits; no result is produced until new items.
// There is no configuration and no memory.
module ldpc_segmentation_params
  import lsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  lsp_in_t  din,
  output logic     busy,
  output logic     done,
  output lsp_out_t dout
);

  assign busy = 1'b0;

  logic        v0;
  logic        bg2;
  logic [21:0] b;
  logic [4:0]  tbcrc;
  logic        multi;

  // Stage one: graph choice, CRC length and B.
  always_ff @(posedge clk) begin
    logic g;
    logic [4:0] cl;
    g = (din.tb_size <= 21'd292)
        || (din.tb_size <= 21'd3824 && {7'd0, din.code_rate} * 18'd100 < 18'd68608)
        || (din.code_rate <= 11'd256);
    cl = (din.tb_size > 21'd3824) ? 5'd24 : 5'd16;
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    bg2   <= g;
    tbcrc <= cl;
    b     <= {1'b0, din.tb_size} + {17'd0, cl};
  end

  always_comb begin
    multi = bg2 ? (b > KcbBg2) : (b > KcbBg1);
  end

  // First division: C = ceil(B / (Kcb - 24)) through (B + den - 1) / den,
  // taken as a multiply by the reciprocal of the constant divisor.
  logic [13:0] den1;
  logic [21:0] num1;
  logic [24:0] recip1;
  logic [45:0] prod0;
  assign den1   = bg2 ? 14'd3816 : 14'd8424;
  assign recip1 = bg2 ? RecipBg2 : RecipBg1;
  assign num1   = b + {8'd0, den1} - 22'd1;
  assign prod0  = {24'd0, num1} * {21'd0, recip1};

  logic        v1;
  logic [9:0]  q1;
  logic        bg2_1, multi_1;
  logic [4:0]  tbcrc_1;
  logic [21:0] b_1;
  logic [9:0]  c_1;
  logic [21:0] bd_1;

  // Register the quotient with the fields that travel beside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    q1      <= prod0[RecipShift+9:RecipShift];
    bg2_1   <= bg2;
    multi_1 <= multi;
    tbcrc_1 <= tbcrc;
    b_1     <= b;
  end

  assign c_1  = multi_1 ? q1 : 10'd1;
  assign bd_1 = multi_1 ? b_1 + {12'd0, c_1} * 22'd24 : b_1;

  // Stage: register the ceiling numerators for the second dividers.
  logic        v2, bg2_2, multi_2;
  logic [4:0]  tbcrc_2;
  logic [21:0] b_2, nb_2, nbd_2;
  logic [9:0]  c_2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    bg2_2   <= bg2_1;
    multi_2 <= multi_1;
    tbcrc_2 <= tbcrc_1;
    b_2     <= b_1;
    c_2     <= c_1;
    nb_2    <= b_1 + {12'd0, c_1} - 22'd1;
    nbd_2   <= bd_1 + {12'd0, c_1} - 22'd1;
  end

  localparam int S2W = 1 + 1 + 5 + 22 + 10;
  logic           v3, v3b;
  logic [21:0]    qb, qbd;
  logic [9:0]     rb, rbd;
  logic [S2W-1:0] s2;
  logic [0:0]     unused_side;

  lsp_div #(.NumW(22), .DenW(10), .SideW(S2W)) u_div_cbz (
    .clk(clk), .rst(rst), .in_vld(v2), .num(nb_2), .den(c_2),
    .side_in({bg2_2, multi_2, tbcrc_2, b_2, c_2}), .out_vld(v3), .quot(qb),
    .rem(rb), .side_out(s2)
  );

  lsp_div #(.NumW(22), .DenW(10), .SideW(1)) u_div_kd (
    .clk(clk), .rst(rst), .in_vld(v2), .num(nbd_2), .den(c_2),
    .side_in(1'b0), .out_vld(v3b), .quot(qbd), .rem(rbd),
    .side_out(unused_side)
  );

  logic        bg2_3, multi_3;
  logic [4:0]  tbcrc_3;
  logic [21:0] b_3;
  logic [9:0]  c_3;
  logic [4:0]  kb;
  lsp_out_t    part;
  assign {bg2_3, multi_3, tbcrc_3, b_3, c_3} = s2;

  // Kb from graph and B, and the fields known before the lifting search.
  always_comb begin
    if (!bg2_3) begin
      kb = 5'd22;
    end else if (b_3 > 22'd640) begin
      kb = 5'd10;
    end else if (b_3 > 22'd560) begin
      kb = 5'd9;
    end else if (b_3 > 22'd192) begin
      kb = 5'd8;
    end else begin
      kb = 5'd6;
    end
    part                = '0;
    part.base_graph     = bg2_3;
    part.tb_crc_len     = tbcrc_3;
    part.tb_bits_crc    = b_3[20:0];
    part.num_blocks     = c_3;
    part.block_crc_len  = multi_3 ? 5'd24 : 5'd0;
    part.bits_per_block = qb[13:0];
    if (v3b && (|rb || |rbd || |unused_side)) begin
      part.lifting_size = '0;
    end
  end

  lsp_lift u_lift (
    .clk(clk), .rst(rst), .in_vld(v3), .kb(kb), .kd(qbd), .part_in(part),
    .out_vld(done), .res(dout)
  );

endmodule
